FILE: rtl/core/ssrp_pkg.sv
// ----------------------------------------------------------------------------
// ssrp_pkg
// Types and constants for the stepper driver register shadow and poll
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrp_pkg;

    localparam int NUM_MOTORS_DEF = 4;
    localparam int NUM_REGS       = 5;

    localparam int CMD_W       = 2;
    localparam int MOTOR_W     = 2;
    localparam int REG_IDX_W   = 3;
    localparam int WORD_W      = 20;
    localparam int RESPONSE_W  = 24;
    localparam int STALL_W     = 10;
    localparam int FLAGS_W     = 8;
    localparam int ERROR_W     = 5;
    localparam int READY_MASK_W = 4;

    localparam int STALL_SHIFT = 14;
    localparam int FLAGS_SHIFT = 4;

    // Request codes
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESYNC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

    // Shadow register indexes
    localparam logic [REG_IDX_W-1:0] REG_DRVCTRL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHOPCONF = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SMARTEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRVCONF = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SGCSCONF = 3'd4;

    // Register address bits on the wire
    localparam logic [WORD_W-1:0] ADDR_DRVCTRL  = 20'h00000;
    localparam logic [WORD_W-1:0] ADDR_CHOPCONF = 20'h80000;
    localparam logic [WORD_W-1:0] ADDR_SMARTEN  = 20'hA0000;
    localparam logic [WORD_W-1:0] ADDR_DRVCONF  = 20'hE0000;
    localparam logic [WORD_W-1:0] ADDR_SGCSCONF = 20'hC0000;

    // Driver status bit positions within the flag byte
    localparam int DF_OT_BIT      = 1;
    localparam int DF_OTPW_BIT    = 2;
    localparam int DF_SHORT_A_BIT = 3;
    localparam int DF_SHORT_B_BIT = 4;
    localparam int DF_OPEN_A_BIT  = 5;
    localparam int DF_OPEN_B_BIT  = 6;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [MOTOR_W-1:0]    motor;
        logic [REG_IDX_W-1:0]  reg_index;
        logic [WORD_W-1:0]     reg_value;
        logic [RESPONSE_W-1:0] response;
        logic                  fault_level;
    } ssrp_req_t;

    typedef struct packed {
        logic                    send_valid;
        logic [MOTOR_W-1:0]      send_motor;
        logic [WORD_W-1:0]       send_word;
        logic                    status_valid;
        logic [MOTOR_W-1:0]      status_motor;
        logic [STALL_W-1:0]      stall_value;
        logic [FLAGS_W-1:0]      driver_flags;
        logic [ERROR_W-1:0]      error_flags;
        logic                    configured_valid;
        logic [MOTOR_W-1:0]      configured_motor;
        logic                    sweep_done;
        logic [READY_MASK_W-1:0] ready_mask;
    } ssrp_res_t;

    typedef struct packed {
        logic                 found;
        logic [REG_IDX_W-1:0] idx;
    } ssrp_pick_t;

    function automatic logic [WORD_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
        logic [WORD_W-1:0] a;
        unique case (idx)
            REG_DRVCTRL:  a = ADDR_DRVCTRL;
            REG_CHOPCONF: a = ADDR_CHOPCONF;
            REG_SMARTEN:  a = ADDR_SMARTEN;
            REG_DRVCONF:  a = ADDR_DRVCONF;
            REG_SGCSCONF: a = ADDR_SGCSCONF;
            default:      a = '0;
        endcase
        return a;
    endfunction

    // Lowest-numbered register whose sent mark is clear
    function automatic ssrp_pick_t first_stale(input logic [NUM_REGS-1:0] marks);
        ssrp_pick_t p;
        p = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (!marks[i]) begin
                p.found = 1'b1;
                p.idx   = REG_IDX_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [ERROR_W-1:0] error_map(input logic [FLAGS_W-1:0] flags,
                                                     input logic fault);
        logic [ERROR_W-1:0] e;
        e    = '0;
        e[0] = flags[DF_SHORT_A_BIT] | flags[DF_SHORT_B_BIT];
        e[1] = flags[DF_OTPW_BIT];
        e[2] = flags[DF_OT_BIT];
        e[3] = flags[DF_OPEN_A_BIT] | flags[DF_OPEN_B_BIT];
        e[4] = fault;
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/stepper_spi_register_sync_poller.sv
// ----------------------------------------------------------------------------
// stepper_spi_register_sync_poller
// Shadow registers and round-robin poll sequencer for serially attached
// stepper driver chips.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and returns exactly one
// result for each. The request is held in an input register, then a single
// pass of logic updates the shadow state and loads the result register.
// The shadow store is a small memory read as the request enters the input
// register, at its own entry for a set and otherwise at the address that the
// preceding request leaves behind (a write from that request at the same
// address is forwarded). A per-entry valid bit makes unwritten entries read
// as zero, so no clearing pass is needed after reset. A request is taken
// while a finished result still waits downstream; req_stall rises only when
// both the input and result registers are full.
`default_nettype none

module stepper_spi_register_sync_poller
    import ssrp_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  ssrp_req_t req,
    output logic      res_valid,
    input  logic      res_stall,
    output ssrp_res_t res
);

    localparam int AW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int DEPTH = NUM_MOTORS * NUM_REGS;
    localparam int SW    = $clog2(DEPTH);

    // Shadow store, one row of NUM_REGS entries per motor
    logic [WORD_W-1:0]     shadow_mem [DEPTH];
    logic [DEPTH-1:0]      shadow_vld_reg;
    logic                  wr_en;
    logic [SW-1:0]         wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic [SW-1:0]         rd_addr;
    logic [WORD_W-1:0]     rd_data_reg;

    // Per-motor control state
    logic [NUM_REGS-1:0]   sent_reg  [NUM_MOTORS];
    logic [NUM_REGS-1:0]   sent_next [NUM_MOTORS];
    logic [WORD_W-1:0]     pend_cmd_reg  [NUM_MOTORS];
    logic [WORD_W-1:0]     pend_cmd_next [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] ready_reg, ready_next;
    logic [NUM_MOTORS-1:0] rsp_pend_reg, rsp_pend_next;
    logic [AW-1:0]         active_reg, active_next;

    // Input and result stages
    logic                  item_valid_reg, item_valid_next;
    ssrp_req_t             item_reg;
    logic                  res_valid_reg, res_valid_next;
    ssrp_res_t             res_reg, res_next;

    logic                  accept;
    logic                  res_free;
    logic                  adv;

    // Handshake: a held request passes when the result register can take it
    assign res_free  = !res_valid_reg || !res_stall;
    assign adv       = item_valid_reg && res_free;
    assign req_stall = item_valid_reg && !adv;
    assign accept    = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (adv)
        begin
            item_valid_next = 1'b0;
        end
        res_valid_next = adv || !res_free;
    end

    // Main pass: works on the held request and the shadow word read with it
    always_comb
    begin
        logic [AW-1:0]         m;
        logic [AW-1:0]         mi;
        logic [AW-1:0]         nm;
        ssrp_pick_t            pick;
        logic [WORD_W-1:0]     word;
        logic [FLAGS_W-1:0]    flags;
        logic                  captured;
        logic                  more;
        logic                  motor_ok;
        logic                  reg_ok;

        sent_next     = sent_reg;
        pend_cmd_next = pend_cmd_reg;
        ready_next    = ready_reg;
        rsp_pend_next = rsp_pend_reg;
        active_next   = active_reg;
        res_next      = '0;
        wr_en         = 1'b0;
        wr_data       = item_reg.reg_value;
        wr_addr       = '0;

        m        = active_reg;
        mi       = AW'(item_reg.motor);
        nm       = m + AW'(1);
        pick     = first_stale(sent_reg[m]);
        word     = reg_addr(pick.found ? pick.idx : REG_DRVCTRL) | rd_data_reg;
        flags    = item_reg.response[FLAGS_SHIFT +: FLAGS_W];
        captured = rsp_pend_reg[m];
        more     = 1'b0;
        motor_ok = int'(item_reg.motor) < NUM_MOTORS;
        reg_ok   = int'(item_reg.reg_index) < NUM_REGS;

        if (adv)
        begin
            unique case (item_reg.command)
                CMD_SET:
                begin
                    // Only a real change makes the register stale
                    if (motor_ok && reg_ok && rd_data_reg != item_reg.reg_value)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = SW'(int'(item_reg.motor) * NUM_REGS
                                      + int'(item_reg.reg_index));
                        sent_next[mi][item_reg.reg_index] = 1'b0;
                        ready_next[mi] = 1'b0;
                    end
                end
                CMD_RESYNC:
                begin
                    if (motor_ok)
                    begin
                        sent_next[mi] = '0;
                    end
                end
                CMD_ADVANCE:
                begin
                    if (captured)
                    begin
                        rsp_pend_next[m]      = 1'b0;
                        res_next.status_valid = 1'b1;
                        res_next.status_motor = MOTOR_W'(m);
                        res_next.stall_value  =
                            item_reg.response[STALL_SHIFT +: STALL_W];
                        res_next.driver_flags = flags;
                        res_next.error_flags  = error_map(flags, item_reg.fault_level);
                    end

                    if (pick.found)
                    begin
                        sent_next[m][pick.idx] = 1'b1;
                        ready_next[m]          = 1'b0;
                        more                   = 1'b1;
                    end
                    else
                    begin
                        if (!ready_reg[m])
                        begin
                            ready_next[m]             = 1'b1;
                            res_next.configured_valid = 1'b1;
                            res_next.configured_motor = MOTOR_W'(m);
                        end
                        more = !captured;
                    end
                    pend_cmd_next[m] = word;

                    if (more)
                    begin
                        // Send again to the same motor
                        rsp_pend_next[m]    = 1'b1;
                        res_next.send_valid = 1'b1;
                        res_next.send_motor = MOTOR_W'(m);
                        res_next.send_word  = word;
                    end
                    else if (int'(m) + 1 == NUM_MOTORS)
                    begin
                        // Wrap: the sweep ends and nothing goes out
                        active_next         = '0;
                        res_next.sweep_done = 1'b1;
                    end
                    else
                    begin
                        active_next         = nm;
                        rsp_pend_next[nm]   = 1'b1;
                        res_next.send_valid = 1'b1;
                        res_next.send_motor = MOTOR_W'(nm);
                        res_next.send_word  = pend_cmd_reg[nm];
                    end
                end
                default:
                begin
                end
            endcase
        end

        for (int i = 0; i < READY_MASK_W; i++)
        begin
            if (i < NUM_MOTORS)
            begin
                res_next.ready_mask[i] = ready_next[i];
            end
        end
    end

    // Read address for the incoming request, taken from the state it will see
    always_comb
    begin
        ssrp_pick_t           rd_pick;
        logic [REG_IDX_W-1:0] rd_idx;

        rd_pick = first_stale(sent_next[active_next]);
        rd_idx  = rd_pick.found ? rd_pick.idx : REG_DRVCTRL;
        if (req.command == CMD_SET && int'(req.motor) < NUM_MOTORS
            && int'(req.reg_index) < NUM_REGS)
        begin
            rd_addr = SW'(int'(req.motor) * NUM_REGS + int'(req.reg_index));
        end
        else
        begin
            rd_addr = SW'(int'(active_next) * NUM_REGS + int'(rd_idx));
        end
    end

    // Shadow memory: one write, one registered read with write forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shadow_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            if (wr_en && wr_addr == rd_addr)
            begin
                rd_data_reg <= wr_data;
            end
            else if (shadow_vld_reg[rd_addr])
            begin
                rd_data_reg <= shadow_mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            shadow_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                sent_reg[i]     <= '0;
                pend_cmd_reg[i] <= '0;
            end
            ready_reg      <= '0;
            rsp_pend_reg   <= '0;
            active_reg     <= '0;
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            sent_reg       <= sent_next;
            pend_cmd_reg   <= pend_cmd_next;
            ready_reg      <= ready_next;
            rsp_pend_reg   <= rsp_pend_next;
            active_reg     <= active_next;
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload stages: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    // At most one response outstanding, and only for the motor being polled
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rsp_pend_reg))
        else $error("more than one driver response pending");

    a_pending_active: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_pend_reg != '0) |-> rsp_pend_reg[active_reg])
        else $error("response pending for a motor other than the active one");

    // End of sweep never starts a transfer
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.sweep_done |-> !res_reg.send_valid)
        else $error("transfer started on the end of a sweep");

    // A newly configured motor shows up as ready in the same result
    a_config_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.configured_valid
        |-> (NUM_MOTORS > READY_MASK_W) || res_reg.ready_mask[res_reg.configured_motor])
        else $error("configured motor not marked ready");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stepper driver register shadow and poll
// sequencer.
// ----------------------------------------------------------------------------
// A local predictor keeps its own copy of the shadow registers, sent marks,
// ready bits, pending responses and the poll position. Each accepted request
// pushes one predicted result, and each accepted result is checked field by
// field against the oldest one. The named tests cover edge values, long
// random traffic, result back-pressure and a burst with no idling.
// ----------------------------------------------------------------------------

module tb_top;
    import ssrp_pkg::*;

    localparam int MOTORS       = NUM_MOTORS_DEF;
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake before giving up
    localparam int SETTLE       = 8;

    // Command and register codes that the package leaves unnamed
    localparam logic [CMD_W-1:0]     CMD_UNKNOWN = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_BAD_LO  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BAD_HI  = 3'd7;

    // Wire address of each shadow register, indexed by register number
    localparam logic [NUM_REGS-1:0][WORD_W-1:0] WIRE_ADDR =
        {ADDR_SGCSCONF, ADDR_DRVCONF, ADDR_SMARTEN, ADDR_CHOPCONF, ADDR_DRVCTRL};

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    ssrp_req_t req;
    logic      res_valid;
    logic      res_stall;
    ssrp_res_t res;

    // Predictor state
    logic [WORD_W-1:0]   shadow_q   [MOTORS][NUM_REGS];
    logic [NUM_REGS-1:0] sent_q     [MOTORS];
    logic                ready_q    [MOTORS];
    logic                awaiting_q [MOTORS];
    logic [WORD_W-1:0]   next_word_q[MOTORS];
    logic [MOTOR_W-1:0]  poll_motor_q;

    ssrp_res_t expected_q[$];

    // Run bookkeeping
    int  n_errors;
    int  n_requests;
    int  n_results;
    int  n_sweeps;
    int  n_configured;
    int  n_status;
    int  n_in_stalled;
    bit  quiet_run;   // no idling on either side
    bit  hold_req;    // ask the receiver for one long hold-off

    stepper_spi_register_sync_poller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one request to the local state, return its result
    // ------------------------------------------------------------------------
    task automatic predict_result(input ssrp_req_t rq, output ssrp_res_t o);
        logic [MOTOR_W-1:0] m;
        logic [FLAGS_W-1:0] flags;
        logic               captured;
        logic               found;
        logic               more;
        o = '0;
        case (rq.command)
            CMD_SET:
            begin
                // Only a real change marks the register stale and drops ready
                if (int'(rq.reg_index) < NUM_REGS &&
                    shadow_q[rq.motor][rq.reg_index] != rq.reg_value)
                begin
                    shadow_q[rq.motor][rq.reg_index] = rq.reg_value;
                    sent_q[rq.motor][rq.reg_index]   = 1'b0;
                    ready_q[rq.motor]                = 1'b0;
                end
            end
            CMD_RESYNC:
                sent_q[rq.motor] = '0;
            CMD_ADVANCE:
            begin
                m        = poll_motor_q;
                captured = 1'b0;
                found    = 1'b0;
                more     = 1'b0;
                // Capture the response of the transfer just finished
                if (awaiting_q[m])
                begin
                    awaiting_q[m]  = 1'b0;
                    captured       = 1'b1;
                    flags          = rq.response[FLAGS_SHIFT +: FLAGS_W];
                    o.status_valid = 1'b1;
                    o.status_motor = m;
                    o.stall_value  = rq.response[STALL_SHIFT +: STALL_W];
                    o.driver_flags = flags;
                    o.error_flags[0] = flags[DF_SHORT_A_BIT] | flags[DF_SHORT_B_BIT];
                    o.error_flags[1] = flags[DF_OTPW_BIT];
                    o.error_flags[2] = flags[DF_OT_BIT];
                    o.error_flags[3] = flags[DF_OPEN_A_BIT] | flags[DF_OPEN_B_BIT];
                    o.error_flags[4] = rq.fault_level;
                end
                // Lowest stale register goes out first
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    if (!found && !sent_q[m][i])
                    begin
                        found          = 1'b1;
                        sent_q[m][i]   = 1'b1;
                        next_word_q[m] = WIRE_ADDR[i] | shadow_q[m][i];
                        ready_q[m]     = 1'b0;
                    end
                end
                if (found)
                    more = 1'b1;
                else
                begin
                    if (!ready_q[m])
                    begin
                        ready_q[m]         = 1'b1;
                        o.configured_valid = 1'b1;
                        o.configured_motor = m;
                    end
                    next_word_q[m] = WIRE_ADDR[REG_DRVCTRL] | shadow_q[m][REG_DRVCTRL];
                    more           = !captured;
                end
                if (!more && int'(m) == MOTORS - 1)
                begin
                    poll_motor_q = '0;
                    o.sweep_done = 1'b1;
                end
                else
                begin
                    if (!more)
                        m = m + 1'b1;
                    poll_motor_q  = m;
                    awaiting_q[m] = 1'b1;
                    o.send_valid  = 1'b1;
                    o.send_motor  = m;
                    o.send_word   = next_word_q[m];
                end
            end
            default: ;
        endcase
        for (int k = 0; k < MOTORS; k++)
            o.ready_mask[k] = ready_q[k];
    endtask

    // ------------------------------------------------------------------------
    // Request monitor: predict on every accepted request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : request_monitor
        ssrp_res_t predicted;
        if (rst_n && req_valid && !req_stall)
        begin
            predict_result(req, predicted);
            expected_q.push_back(predicted);
            n_requests++;
        end
        if (rst_n && req_valid && req_stall)
            n_in_stalled++;
    end

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (act_v !== exp_v)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        ssrp_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with nothing expected, actual %h", $time, res);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("send_valid", 24'(want.send_valid), 24'(res.send_valid));
                check_field("send_motor", 24'(want.send_motor), 24'(res.send_motor));
                check_field("send_word", 24'(want.send_word), 24'(res.send_word));
                check_field("status_valid", 24'(want.status_valid), 24'(res.status_valid));
                check_field("status_motor", 24'(want.status_motor), 24'(res.status_motor));
                check_field("stall_value", 24'(want.stall_value), 24'(res.stall_value));
                check_field("driver_flags", 24'(want.driver_flags), 24'(res.driver_flags));
                check_field("error_flags", 24'(want.error_flags), 24'(res.error_flags));
                check_field("configured_valid", 24'(want.configured_valid),
                            24'(res.configured_valid));
                check_field("configured_motor", 24'(want.configured_motor),
                            24'(res.configured_motor));
                check_field("sweep_done", 24'(want.sweep_done), 24'(res.sweep_done));
                check_field("ready_mask", 24'(want.ready_mask), 24'(res.ready_mask));
                if (want.sweep_done)       n_sweeps++;
                if (want.configured_valid) n_configured++;
                if (want.status_valid)     n_status++;
            end
        end
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if (quiet_run)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(0, 2);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall segments, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int seg;
        bit stalling;
        res_stall = 1'b0;
        seg       = 0;
        stalling  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // Hold results back long enough for the block to fill up
                hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_stall <= 1'b0;
                stalling = 1'b0;
                seg      = 0;
            end
            else if (quiet_run)
                res_stall <= 1'b0;
            else
            begin
                if (seg == 0)
                begin
                    stalling = !stalling;
                    seg      = stalling ? pick_gap() : $urandom_range(1, 6);
                end
                if (seg == 0)
                begin
                    stalling = 1'b0;
                    seg      = $urandom_range(1, 6);
                end
                res_stall <= stalling;
                seg--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up once nothing has moved for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Offer one request and return at the edge that accepts it; valid stays
    // high so that a following request goes out back to back
    task automatic send_request(input ssrp_req_t item);
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Drop valid for the requested gap length
    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic ssrp_req_t make_req(input logic [CMD_W-1:0] cmd,
                                           input logic [MOTOR_W-1:0] motor,
                                           input logic [REG_IDX_W-1:0] idx,
                                           input logic [WORD_W-1:0] value,
                                           input logic [RESPONSE_W-1:0] resp,
                                           input logic fault);
        ssrp_req_t r;
        r.command     = cmd;
        r.motor       = motor;
        r.reg_index   = idx;
        r.reg_value   = value;
        r.response    = resp;
        r.fault_level = fault;
        return r;
    endfunction

    // Random request: mostly advances so that motors configure and sweeps
    // complete, with sets, resyncs and noise mixed in
    function automatic ssrp_req_t random_request();
        ssrp_req_t r;
        int        sel;
        sel           = $urandom_range(0, 99);
        r.motor       = MOTOR_W'($urandom_range(0, 3));
        r.reg_index   = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
        r.reg_value   = WORD_W'($urandom_range(0, 20'hFFFFF));
        r.response    = RESPONSE_W'($urandom_range(0, 24'hFFFFFF));
        r.fault_level = 1'($urandom_range(0, 1));
        if (sel < 62)
            r.command = CMD_ADVANCE;
        else if (sel < 88)
        begin
            r.command = CMD_SET;
            case ($urandom_range(0, 9))
                0: r.reg_index = REG_IDX_W'($urandom_range(int'(REG_BAD_LO),
                                                           int'(REG_BAD_HI)));
                1, 2: r.reg_value = shadow_q[r.motor][r.reg_index];  // likely unchanged
                3: r.reg_value = 20'hFFFFF;
                4: r.reg_value = '0;
                default: ;
            endcase
        end
        else if (sel < 95)
            r.command = CMD_RESYNC;
        else
            r.command = CMD_UNKNOWN;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge values, every command, ignored and unchanged writes, flag mapping
    task automatic test_directed_edges();
        logic [RESPONSE_W-1:0] resp;
        send_request(make_req(CMD_UNKNOWN, 2'd3, REG_BAD_HI, 20'hFFFFF, 24'hFFFFFF, 1'b1));
        send_request(make_req(CMD_SET, 2'd0, REG_BAD_HI, 20'hFFFFF, '0, 1'b0));
        send_request(make_req(CMD_SET, 2'd2, REG_BAD_LO, 20'h12345, '0, 1'b0));
        send_request(make_req(CMD_SET, 2'd3, REG_SGCSCONF, 20'hFFFFF, '0, 1'b0));
        // same value again: no change
        send_request(make_req(CMD_SET, 2'd3, REG_SGCSCONF, 20'hFFFFF, '0, 1'b0));
        // reset value written back: no change
        send_request(make_req(CMD_SET, 2'd0, REG_DRVCTRL, '0, '0, 1'b0));
        send_request(make_req(CMD_SET, 2'd1, REG_CHOPCONF, 20'hA5A5A, '0, 1'b0));
        // first advance has nothing to capture
        send_request(make_req(CMD_ADVANCE, '0, '0, '0, 24'hFFFFFF, 1'b1));
        for (int k = 0; k < 14; k++)
        begin
            case (k % 11)
                0:       resp = 24'hFFFFFF;
                1:       resp = '0;
                10:      resp = 24'h3FF << STALL_SHIFT;
                default: resp = 24'h1 << (FLAGS_SHIFT + (k % 11) - 1);
            endcase
            send_request(make_req(CMD_ADVANCE, 2'd3, REG_BAD_HI, 20'hFFFFF, resp, k[0]));
            idle_sender(pick_gap());
        end
        send_request(make_req(CMD_RESYNC, 2'd3, '0, '0, '0, 1'b0));
        send_request(make_req(CMD_SET, 2'd0, REG_DRVCONF, 20'h00001, '0, 1'b0));
        send_request(make_req(CMD_ADVANCE, '0, '0, '0, 24'h5A5A5A, 1'b0));
        drain_results();
    endtask

    // Long random run with random gaps on both sides
    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_request(random_request());
            idle_sender(pick_gap());
        end
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering: the block fills up
    // and must stall its input without losing a request
    task automatic test_result_backpressure(input int count);
        hold_req = 1'b1;
        for (int n = 0; n < count; n++)
            send_request(random_request());
        drain_results();
    endtask

    // Back-to-back requests with the receiver always ready
    task automatic test_back_to_back(input int count);
        quiet_run = 1'b1;
        for (int n = 0; n < count; n++)
            send_request(random_request());
        drain_results();
        quiet_run = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Drive every input and clear predictor state before the first edge
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        quiet_run    = 1'b0;
        hold_req     = 1'b0;
        n_errors     = 0;
        n_requests   = 0;
        n_results    = 0;
        n_sweeps     = 0;
        n_configured = 0;
        n_status     = 0;
        n_in_stalled = 0;
        poll_motor_q = '0;
        for (int m = 0; m < MOTORS; m++)
        begin
            for (int r = 0; r < NUM_REGS; r++)
                shadow_q[m][r] = '0;
            sent_q[m]      = '0;
            ready_q[m]     = 1'b0;
            awaiting_q[m]  = 1'b0;
            next_word_q[m] = '0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_random_traffic(920);
        test_result_backpressure(40);
        test_back_to_back(120);

        // Let any stray result show up before judging
        repeat (SETTLE) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d results never arrived", $time, expected_q.size());
        end

        $display("covered %0d requests, %0d results: %0d sweeps, %0d configured, %0d captures",
                 n_requests, n_results, n_sweeps, n_configured, n_status);
        $display("input held off for %0d cycles while results were backed up", n_in_stalled);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: stepper_spi_register_sync_poller.f
rtl/core/ssrp_pkg.sv
rtl/core/stepper_spi_register_sync_poller.sv
tb/tb_top.sv
